// ===== rtl/bpsr_pkg.sv =====
// shared types and constants for the block partition bin scatter router
package bpsr_pkg;

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_SCATTER = 1'b1;

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_CNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BASE = 3'd4;

  // quotient bits: core_count is 7 bits, so any owner of 128 or more is dropped
  localparam int OWNER_W = 7;
  localparam int SLAB_W  = 21;
  localparam int REM_W   = SLAB_W + OWNER_W;
  // width that holds any core limit up to 256
  localparam int MAXC_W  = 9;

  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = 2;
  localparam int MID_CNT_W = 3;

  localparam int OUT_DEPTH = 16;
  localparam int OUT_PTR_W = 4;
  localparam int OUT_CNT_W = 5;

  typedef struct packed {
    logic        command;
    logic [15:0] bin_x;
    logic [15:0] bin_y;
    logic [31:0] area;
    logic [5:0]  entry_index;
    logic [31:0] entry_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [31:0] dest_addr;
    logic [31:0] increment;
  } out_item_t;

  typedef struct packed {
    logic [15:0]       bins_x;
    logic [15:0]       bins_y;
    logic [SLAB_W-1:0] slab_len;
    logic [6:0]        core_count;
    logic [31:0]       slab_base_addr;
  } cfg_t;

  // classified item between front and back: value is the global bin or the table word
  typedef struct packed {
    logic        is_load;
    logic [5:0]  entry_index;
    logic [31:0] value;
    logic [31:0] area;
  } mid_t;

endpackage

// ===== rtl/bpsr_front.sv =====
// front end: accepts items, checks ranges and forms the global bin index
module bpsr_front #(
  parameter int MAX_CORES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bpsr_pkg::cfg_t     cfg,
  input  logic               in_push,
  input  bpsr_pkg::in_item_t in_data,
  output logic               in_full,
  input  logic               q_full,
  output logic               q_push,
  output bpsr_pkg::mid_t     q_data
);
  import bpsr_pkg::*;

  localparam logic [MAXC_W-1:0] MAX_C = MAXC_W'(MAX_CORES);

  logic        s1_v_r;
  logic        s1_load_r;
  logic        s1_ok_r;
  logic [31:0] s1_prod_r;
  logic [15:0] s1_by_r;
  logic [31:0] s1_area_r;
  logic [5:0]  s1_idx_r;
  logic [31:0] s1_word_r;

  logic        in_ok;
  logic        in_acc;
  logic        keep;
  logic        s1_free;
  logic [31:0] prod;
  logic [31:0] global_bin;
  logic [31:0] span;

  always_comb begin
    if (in_data.command == CMD_LOAD) begin
      in_ok = MAXC_W'(in_data.entry_index) < MAX_C;
    end else begin
      in_ok = (in_data.bin_x < cfg.bins_x) && (in_data.bin_y < cfg.bins_y) &&
              (in_data.area != '0) && (cfg.slab_len != '0);
    end
  end

  assign prod = 32'(in_data.bin_x) * 32'(cfg.bins_y);

  // owner >= 2^OWNER_W is out of range for any core count
  assign span       = 32'({cfg.slab_len, {OWNER_W{1'b0}}});
  assign global_bin = s1_prod_r + 32'(s1_by_r);
  assign keep       = s1_ok_r && (s1_load_r || (global_bin < span));

  assign q_push  = s1_v_r && keep && !q_full;
  assign s1_free = !s1_v_r || !keep || !q_full;
  assign in_full = !s1_free;
  assign in_acc  = in_push && s1_free;

  always_comb begin
    q_data.is_load     = s1_load_r;
    q_data.entry_index = s1_idx_r;
    q_data.value       = s1_load_r ? s1_word_r : global_bin;
    q_data.area        = s1_area_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_push;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_load_r <= (in_data.command == CMD_LOAD);
      s1_ok_r   <= in_ok;
      s1_prod_r <= prod;
      s1_by_r   <= in_data.bin_y;
      s1_area_r <= in_data.area;
      s1_idx_r  <= in_data.entry_index;
      s1_word_r <= in_data.entry_word;
    end
  end

endmodule

// ===== rtl/bpsr_queue.sv =====
// short queue of classified items between front and back
module bpsr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bpsr_pkg::mid_t push_data,
  output logic           full,
  input  logic           pop,
  output bpsr_pkg::mid_t pop_data,
  output logic           empty
);
  import bpsr_pkg::*;

  mid_t                 mem_r [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr_r;
  logic [MID_PTR_W-1:0] rd_ptr_r;
  logic [MID_CNT_W-1:0] cnt_r;
  logic [MID_CNT_W-1:0] cnt_nxt;
  logic                 push_ok;
  logic                 pop_ok;

  assign full     = (cnt_r == MID_CNT_W'(MID_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign cnt_nxt  = cnt_r + MID_CNT_W'(push_ok) - MID_CNT_W'(pop_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) wr_ptr_r <= wr_ptr_r + MID_PTR_W'(1);
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + MID_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/bpsr_back.sv =====
// back end: pipelined slab divider, owner table and result queue
module bpsr_back #(
  parameter int MAX_CORES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bpsr_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  bpsr_pkg::mid_t      q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output bpsr_pkg::out_item_t out_data
);
  import bpsr_pkg::*;

  localparam int IDX_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam logic [MAXC_W-1:0] MAX_C = MAXC_W'(MAX_CORES);

  // divider stages: stage 0 is the entry, stage OWNER_W holds quotient and remainder
  logic [OWNER_W:0] st_v_r;
  logic [OWNER_W:0] st_load_r;
  logic [31:0]      st_val_r  [OWNER_W+1];
  logic [OWNER_W-1:0] st_q_r  [OWNER_W+1];
  logic [31:0]      st_area_r [OWNER_W+1];
  logic [5:0]       st_idx_r  [OWNER_W+1];

  logic [31:0]        val_nxt [OWNER_W+1];
  logic [OWNER_W-1:0] q_nxt   [OWNER_W+1];
  logic [REM_W-1:0]   sub     [OWNER_W];

  logic [31:0] tbl_r [MAX_CORES];
  logic [31:0] rd_r;

  logic        f_v_r;
  logic        f_emit_r;
  logic [31:0] f_addr_r;
  logic [31:0] f_area_r;

  out_item_t            out_mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] out_wr_r;
  logic [OUT_PTR_W-1:0] out_rd_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;
  logic [OUT_CNT_W-1:0] out_cnt_nxt;
  logic [OUT_CNT_W-1:0] occ_r;
  logic [OUT_CNT_W-1:0] occ_nxt;

  logic              take;
  logic              drop_fin;
  logic              out_push;
  logic              pop_ok;
  logic [MAXC_W-1:0] owner_x;
  logic [MAXC_W-1:0] wr_x;
  logic              emit_nxt;
  logic [31:0]       addr_nxt;
  out_item_t         out_entry;

  // occ counts every item past the queue until it leaves, so the result queue never overflows
  assign take     = !q_empty && (occ_r < OUT_CNT_W'(OUT_DEPTH));
  assign q_pop    = take;
  assign drop_fin = f_v_r && !f_emit_r;
  assign out_push = f_v_r && f_emit_r;
  assign pop_ok   = out_pop && !out_empty;

  assign occ_nxt     = occ_r + OUT_CNT_W'(take) - OUT_CNT_W'(drop_fin) - OUT_CNT_W'(pop_ok);
  assign out_cnt_nxt = out_cnt_r + OUT_CNT_W'(out_push) - OUT_CNT_W'(pop_ok);

  // restoring division, one quotient bit per stage
  always_comb begin
    val_nxt[0] = q_data.value;
    q_nxt[0]   = '0;
    for (int i = 0; i < OWNER_W; i++) begin
      sub[i]       = REM_W'(cfg.slab_len) << (OWNER_W - 1 - i);
      val_nxt[i+1] = st_val_r[i];
      q_nxt[i+1]   = st_q_r[i];
      if (!st_load_r[i] && (st_val_r[i][REM_W-1:0] >= sub[i])) begin
        val_nxt[i+1][REM_W-1:0]    = st_val_r[i][REM_W-1:0] - sub[i];
        q_nxt[i+1][OWNER_W-1-i] = 1'b1;
      end
    end
  end

  assign owner_x  = MAXC_W'(st_q_r[OWNER_W]);
  assign wr_x     = MAXC_W'(st_idx_r[OWNER_W]);
  assign emit_nxt = !st_load_r[OWNER_W] && (st_q_r[OWNER_W] < cfg.core_count) &&
                    (owner_x < MAX_C);
  assign addr_nxt = cfg.slab_base_addr + 32'({st_val_r[OWNER_W][SLAB_W-1:0], 2'b00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r    <= '0;
      f_v_r     <= 1'b0;
      occ_r     <= '0;
      out_wr_r  <= '0;
      out_rd_r  <= '0;
      out_cnt_r <= '0;
    end else begin
      st_v_r    <= {st_v_r[OWNER_W-1:0], take};
      f_v_r     <= st_v_r[OWNER_W];
      occ_r     <= occ_nxt;
      out_cnt_r <= out_cnt_nxt;
      if (out_push) out_wr_r <= out_wr_r + OUT_PTR_W'(1);
      if (pop_ok)   out_rd_r <= out_rd_r + OUT_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    st_load_r[0] <= q_data.is_load;
    st_val_r[0]  <= val_nxt[0];
    st_q_r[0]    <= q_nxt[0];
    st_area_r[0] <= q_data.area;
    st_idx_r[0]  <= q_data.entry_index;
    for (int i = 0; i < OWNER_W; i++) begin
      st_load_r[i+1] <= st_load_r[i];
      st_val_r[i+1]  <= val_nxt[i+1];
      st_q_r[i+1]    <= q_nxt[i+1];
      st_area_r[i+1] <= st_area_r[i];
      st_idx_r[i+1]  <= st_idx_r[i];
    end
  end

  // owner table: loads and lookups meet it in item order at one stage
  always_ff @(posedge clk) begin
    if (st_v_r[OWNER_W]) begin
      if (st_load_r[OWNER_W]) begin
        tbl_r[wr_x[IDX_W-1:0]] <= st_val_r[OWNER_W];
      end else begin
        rd_r <= tbl_r[owner_x[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    f_emit_r <= emit_nxt;
    f_addr_r <= addr_nxt;
    f_area_r <= st_area_r[OWNER_W];
  end

  always_comb begin
    out_entry.dest_x    = rd_r[15:0];
    out_entry.dest_y    = rd_r[31:16];
    out_entry.dest_addr = f_addr_r;
    out_entry.increment = f_area_r;
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_mem_r[out_wr_r] <= out_entry;
    end
  end

  assign out_empty = (out_cnt_r == '0);
  assign out_data  = out_mem_r[out_rd_r];

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("in-flight count above result queue depth");

  a_cnt_in_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= occ_r)
    else $error("result queue holds more items than counted in flight");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (out_cnt_r != OUT_CNT_W'(OUT_DEPTH)))
    else $error("result pushed into a full queue");

  a_take_enters: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> st_v_r[0])
    else $error("item taken from queue did not enter the divider");
`endif

endmodule

// ===== rtl/block_partition_bin_scatter_router_unit.sv =====
// top level of the block partition bin scatter router
//
//   channel | ports                            | handshake
//   --------+----------------------------------+----------------------------------
//   input   | in_push, in_full, in_data        | item taken when in_push && !in_full
//   result  | out_empty, out_pop, out_data     | item taken when out_pop && !out_empty
//   config  | cfg_we, cfg_index, cfg_wdata     | register written when cfg_we
//
// one item per cycle sustained while in_full stays low; each result passes through
// the slab divider, the owner table read and the queues
// reset is synchronous: config registers go to their reset values, all queues empty,
// owner table entries are undefined until loaded
// in_full rises only when the 4-entry middle queue fills; the back end stops taking
// items when 16 are in flight between the divider and the 16-entry result queue
module block_partition_bin_scatter_router_unit #(
  parameter int MAX_CORES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  bpsr_pkg::in_item_t                  in_data,
  output logic                                in_full,
  output logic                                out_empty,
  input  logic                                out_pop,
  output bpsr_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bpsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_wdata
);
  import bpsr_pkg::*;

  cfg_t cfg_r;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  mid_t q_in;
  mid_t q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bins_x         <= 16'd1;
      cfg_r.bins_y         <= 16'd1;
      cfg_r.slab_len       <= SLAB_W'(1);
      cfg_r.core_count     <= 7'd1;
      cfg_r.slab_base_addr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BINS_X:    cfg_r.bins_x         <= cfg_wdata[15:0];
        CFG_BINS_Y:    cfg_r.bins_y         <= cfg_wdata[15:0];
        CFG_SLAB_LEN:  cfg_r.slab_len       <= cfg_wdata[SLAB_W-1:0];
        CFG_CORE_CNT:  cfg_r.core_count     <= cfg_wdata[6:0];
        CFG_SLAB_BASE: cfg_r.slab_base_addr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpsr_front #(
    .MAX_CORES(MAX_CORES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  bpsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  bpsr_back #(
    .MAX_CORES(MAX_CORES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
